// ===== hdl/addressable_led_serial_encoder_macros.svh =====
// assertion helpers used by the checker of this block
`ifndef ADDRESSABLE_LED_SERIAL_ENCODER_MACROS_SVH
`define ADDRESSABLE_LED_SERIAL_ENCODER_MACROS_SVH

// same-cycle implication, off while reset is held
`define ALED_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aled assertion failed");

// next-cycle implication, off while reset is held
`define ALED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aled assertion failed");

`endif

// ===== hdl/aled_pkg.sv =====
package aled_pkg;

  localparam int unsigned NUM_PIXELS  = 64;
  localparam int unsigned PIX_AW      = $clog2(NUM_PIXELS);
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned CNT_W       = 12;
  localparam int unsigned LATCH_W     = 16;
  localparam int unsigned PIXCNT_W    = 7;
  localparam int unsigned BITPOS_W    = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [BITPOS_W-1:0] FIRST_BIT = BITPOS_W'(COLOR_W - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_REFRESH = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_REFRESH,
    OP_SKIP
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RISE      = 3'd0,
    REG_ZERO_FALL = 3'd1,
    REG_ONE_FALL  = 3'd2,
    REG_PERIOD    = 3'd3,
    REG_LATCH_END = 3'd4,
    REG_PIXELS    = 3'd5
  } reg_e;

  typedef struct packed {
    op_e                op;
    logic [PIX_AW-1:0]  idx;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]    rise;
    logic [CNT_W-1:0]    zero_fall;
    logic [CNT_W-1:0]    one_fall;
    logic [CNT_W-1:0]    period;
    logic [LATCH_W-1:0]  latch_end;
    logic [PIXCNT_W-1:0] pixels;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    rise:      12'd1,
    zero_fall: 12'd31,
    one_fall:  12'd61,
    period:    12'd120,
    latch_end: 16'd8120,
    pixels:    7'd2
  };

endpackage

// ===== hdl/aled_if.sv =====
interface aled_item_if;
  import aled_pkg::*;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [IDX_W-1:0]   pixel_index;
  logic [COLOR_W-1:0] color;
  modport source (output valid, action, pixel_index, color, input ready);
  modport sink   (input valid, action, pixel_index, color, output ready);
endinterface

interface aled_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  modport source (output valid, line_level, busy_res, input ready);
  modport sink   (input valid, line_level, busy_res, output ready);
endinterface

interface aled_cfg_if;
  import aled_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/addressable_led_serial_encoder.sv =====
// path: an accepted word goes into the command queue, then into the back-end state registers, which drive the result
// throughput: one word per cycle while the result is taken; the back end holds off while a shown result stalls
// a 4-entry command queue lets the input side run on while results stall
// reset: asynchronous, active low; clears control state, the pixel valid
// bits (store reads as zero until written) and loads the default timing
module addressable_led_serial_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  aled_item_if.sink  item_i,
  aled_cfg_if.sink   cfg_i,
  aled_res_if.source result_o
);
  import aled_pkg::*;

  cmd_t push_data;
  cmd_t pop_data;
  cfg_t cfg;
  logic push;
  logic pop;
  logic full;
  logic empty;

  aled_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cfg_i    (cfg_i),
    .q_full_i (full),
    .q_push_o (push),
    .q_data_o (push_data),
    .cfg_o    (cfg)
  );

  aled_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty)
  );

  aled_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_empty_i (empty),
    .q_data_i  (pop_data),
    .q_pop_o   (pop),
    .result_o  (result_o)
  );

endmodule

// ===== hdl/aled_front.sv =====
module aled_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  aled_item_if.sink      item_i,
  aled_cfg_if.sink       cfg_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output aled_pkg::cmd_t q_data_o,
  output aled_pkg::cfg_t cfg_o
);
  import aled_pkg::*;

  cfg_t cfg_d, cfg_q;
  logic idx_ok;

  assign item_i.ready = !q_full_i;
  assign q_push_o     = item_i.valid && !q_full_i;
  assign idx_ok       = 32'(item_i.pixel_index) < NUM_PIXELS;

  // writes past the store turn into no-ops here
  always_comb begin
    q_data_o.idx   = PIX_AW'(item_i.pixel_index);
    q_data_o.color = item_i.color;
    unique case (action_e'(item_i.action))
      ACT_TICK:    q_data_o.op = OP_TICK;
      ACT_WRITE:   q_data_o.op = idx_ok ? OP_WRITE : OP_SKIP;
      ACT_REFRESH: q_data_o.op = OP_REFRESH;
      ACT_NONE:    q_data_o.op = OP_SKIP;
      default:     q_data_o.op = OP_SKIP;
    endcase
  end

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_RISE:      cfg_d.rise      = cfg_i.data[CNT_W-1:0];
        REG_ZERO_FALL: cfg_d.zero_fall = cfg_i.data[CNT_W-1:0];
        REG_ONE_FALL:  cfg_d.one_fall  = cfg_i.data[CNT_W-1:0];
        REG_PERIOD:    cfg_d.period    = cfg_i.data[CNT_W-1:0];
        REG_LATCH_END: cfg_d.latch_end = cfg_i.data[LATCH_W-1:0];
        REG_PIXELS:    cfg_d.pixels    = cfg_i.data[PIXCNT_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/aled_fifo.sv =====
module aled_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  aled_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output aled_pkg::cmd_t data_o,
  output logic           empty_o
);
  import aled_pkg::*;

  cmd_t                store_q [QUEUE_DEPTH];
  logic [QUEUE_AW:0]   wptr_d, wptr_q;
  logic [QUEUE_AW:0]   rptr_d, rptr_q;

  assign empty_o = wptr_q == rptr_q;
  assign full_o  = (wptr_q[QUEUE_AW] != rptr_q[QUEUE_AW]) &&
                   (wptr_q[QUEUE_AW-1:0] == rptr_q[QUEUE_AW-1:0]);
  assign data_o  = store_q[rptr_q[QUEUE_AW-1:0]];

  assign wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
  assign rptr_d = pop_i  ? rptr_q + 1'b1 : rptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wptr_q[QUEUE_AW-1:0]] <= data_i;
    end
  end

endmodule

// ===== hdl/aled_back.sv =====
module aled_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  aled_pkg::cfg_t cfg_i,
  input  logic           q_empty_i,
  input  aled_pkg::cmd_t q_data_i,
  output logic           q_pop_o,
  aled_res_if.source     result_o
);
  import aled_pkg::*;

  logic [COLOR_W-1:0]  mem [NUM_PIXELS];
  logic [NUM_PIXELS-1:0] vld_q;
  logic [COLOR_W-1:0]  rdata_q;
  logic                rvld_q;
  logic                fwd_hit_q;
  logic [COLOR_W-1:0]  fwd_data_q;

  logic [PIXCNT_W-1:0] pc_d, pc_q;
  logic [BITPOS_W-1:0] bitpos_d, bitpos_q;
  logic [LATCH_W-1:0]  tick_d, tick_q;
  logic                gap_d, gap_q;
  logic                busy_d, busy_q;
  logic                line_d, line_q;
  logic [COLOR_W-1:0]  word_d, word_q;
  logic [COLOR_W-1:0]  word0_d, word0_q;
  logic                out_valid_d, out_valid_q;

  logic                pop;
  logic                wr_en;
  logic [PIXCNT_W-1:0] nidx;
  logic                nidx_ok;
  logic [PIX_AW-1:0]   raddr;
  logic [COLOR_W-1:0]  next_word;
  logic [LATCH_W-1:0]  t;
  logic                ev_en;
  logic [LATCH_W-1:0]  ev_tick;
  logic [COLOR_W-1:0]  ev_word;
  logic [BITPOS_W-1:0] ev_pos;
  logic [31:0]         ev_ext;
  logic                ev_bit;

  assign pop     = !q_empty_i && (!out_valid_q || result_o.ready);
  assign q_pop_o = pop;
  assign wr_en   = pop && (q_data_i.op == OP_WRITE);

  // next pixel is prefetched; a pixel lasts at least 24 ticks so the read
  // address has settled long before the data is needed
  assign nidx    = pc_q + 1'b1;
  assign nidx_ok = 32'(nidx) < NUM_PIXELS;
  assign raddr   = nidx[PIX_AW-1:0];

  always_comb begin
    if (!nidx_ok) begin
      next_word = '0;
    end else if (fwd_hit_q) begin
      next_word = fwd_data_q;
    end else if (rvld_q) begin
      next_word = rdata_q;
    end else begin
      next_word = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
    if (wr_en) begin
      mem[q_data_i.idx] <= q_data_i.color;
    end
    fwd_data_q <= q_data_i.color;
  end

  assign t = tick_q + 1'b1;

  always_comb begin
    pc_d     = pc_q;
    bitpos_d = bitpos_q;
    tick_d   = tick_q;
    gap_d    = gap_q;
    busy_d   = busy_q;
    line_d   = line_q;
    word_d   = word_q;
    word0_d  = word0_q;
    ev_en    = 1'b0;
    ev_tick  = '0;
    ev_word  = word_q;
    ev_pos   = bitpos_q;
    if (pop) begin
      unique case (q_data_i.op)
        OP_TICK: begin
          if (busy_q) begin
            if (gap_q) begin
              line_d = 1'b0;
              if (t == cfg_i.latch_end) begin
                busy_d = 1'b0;
                gap_d  = 1'b0;
                tick_d = '0;
              end else begin
                tick_d = t;
              end
            end else if (t >= LATCH_W'(cfg_i.period)) begin
              if (bitpos_q != '0) begin
                bitpos_d = bitpos_q - 1'b1;
                tick_d   = '0;
                ev_en    = 1'b1;
                ev_pos   = bitpos_q - 1'b1;
              end else begin
                // end of pixel: line drops, then next pixel or latch gap
                line_d = 1'b0;
                pc_d   = nidx;
                if (nidx < cfg_i.pixels) begin
                  bitpos_d = FIRST_BIT;
                  word_d   = next_word;
                  tick_d   = '0;
                  ev_en    = 1'b1;
                  ev_word  = next_word;
                  ev_pos   = FIRST_BIT;
                end else begin
                  gap_d = 1'b1;
                  if (t == cfg_i.latch_end) begin
                    busy_d = 1'b0;
                    gap_d  = 1'b0;
                    tick_d = '0;
                  end else begin
                    tick_d = t;
                  end
                end
              end
            end else begin
              tick_d  = t;
              ev_en   = 1'b1;
              ev_tick = t;
            end
          end
        end
        OP_WRITE: begin
          if (q_data_i.idx == '0) begin
            word0_d = q_data_i.color;
          end
        end
        OP_REFRESH: begin
          busy_d   = 1'b1;
          gap_d    = 1'b0;
          pc_d     = '0;
          bitpos_d = FIRST_BIT;
          tick_d   = '0;
          word_d   = word0_q;
          ev_en    = 1'b1;
          ev_word  = word0_q;
          ev_pos   = FIRST_BIT;
        end
        OP_SKIP: begin
        end
        default: begin
        end
      endcase
    end
    // timing events at the new count, fall wins over rise
    ev_ext = {{(32 - COLOR_W){1'b0}}, ev_word};
    ev_bit = ev_ext[ev_pos];
    if (ev_en) begin
      if (ev_tick == LATCH_W'(cfg_i.rise)) begin
        line_d = 1'b1;
      end
      if ((ev_tick == LATCH_W'(cfg_i.one_fall)) ||
          (!ev_bit && (ev_tick == LATCH_W'(cfg_i.zero_fall)))) begin
        line_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      fwd_hit_q   <= 1'b0;
      pc_q        <= '0;
      bitpos_q    <= FIRST_BIT;
      tick_q      <= '0;
      gap_q       <= 1'b0;
      busy_q      <= 1'b0;
      line_q      <= 1'b0;
      word_q      <= '0;
      word0_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[q_data_i.idx] <= 1'b1;
      end
      rvld_q      <= vld_q[raddr];
      fwd_hit_q   <= wr_en && (q_data_i.idx == raddr);
      pc_q        <= pc_d;
      bitpos_q    <= bitpos_d;
      tick_q      <= tick_d;
      gap_q       <= gap_d;
      busy_q      <= busy_d;
      line_q      <= line_d;
      word_q      <= word_d;
      word0_q     <= word0_d;
      out_valid_q <= out_valid_d;
    end
  end

  // state only moves on a pop, so it doubles as the output register
  assign result_o.valid      = out_valid_q;
  assign result_o.line_level = line_q;
  assign result_o.busy_res   = busy_q;

endmodule

// ===== hdl/aled_checker.sv =====
`include "addressable_led_serial_encoder_macros.svh"

module aled_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic item_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic line_i,
  input logic busy_i
);

  // the queue can only fill up behind a stalled result
  `ALED_ASSERT_IMPLY(a_backpressure_from_output, clk_i, rst_ni, !item_ready_i, res_valid_i)

  // a finished frame always leaves the line low
  `ALED_ASSERT_IMPLY(a_idle_line_low, clk_i, rst_ni, res_valid_i && !busy_i, !line_i)

  `ALED_ASSERT_NEXT(a_stalled_result_holds, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(line_i) && $stable(busy_i))

endmodule

bind addressable_led_serial_encoder aled_checker u_aled_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_ready_i (item_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .line_i       (result_o.line_level),
  .busy_i       (result_o.busy_res)
);

// ===== dv/tb_top.sv =====
module tb_top;
  import aled_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int unsigned RANDOM_END   = 900;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic line;
    logic busy;
  } level_pair_t;

  typedef struct packed {
    action_e            act;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
    logic               typed;
    logic               line;
    logic               busy;
  } dir_row_t;

  // default timing after reset; typed rows are read straight off the timing rules
  localparam dir_row_t DIR_ROWS [14] = '{
    '{ACT_TICK,    7'd0,   24'h000000, 1'b1, 1'b0, 1'b0},
    '{ACT_NONE,    7'd127, 24'hFFFFFF, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,   7'd0,   24'hFFFFFF, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,   7'd63,  24'h000000, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,   7'd64,  24'hAAAAAA, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,   7'd127, 24'h555555, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,   7'd1,   24'h800001, 1'b1, 1'b0, 1'b0},
    '{ACT_REFRESH, 7'd0,   24'h000000, 1'b1, 1'b0, 1'b1},
    '{ACT_TICK,    7'd0,   24'h000000, 1'b1, 1'b1, 1'b1},
    '{ACT_TICK,    7'd127, 24'hFFFFFF, 1'b0, 1'b0, 1'b0},
    '{ACT_WRITE,   7'd0,   24'h000000, 1'b0, 1'b0, 1'b0},
    '{ACT_REFRESH, 7'd5,   24'h123456, 1'b0, 1'b0, 1'b0},
    '{ACT_TICK,    7'd64,  24'h000000, 1'b0, 1'b0, 1'b0},
    '{ACT_NONE,    7'd0,   24'h000000, 1'b0, 1'b0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  aled_item_if item_if ();
  aled_cfg_if  cfg_if ();
  aled_res_if  res_if ();

  addressable_led_serial_encoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .cfg_i    (cfg_if),
    .result_o (res_if)
  );

  // line model state
  logic [COLOR_W-1:0]  color_mem [NUM_PIXELS];
  logic [COLOR_W-1:0]  cur_color = '0;
  logic [PIXCNT_W-1:0] pix_no    = '0;
  logic [BITPOS_W-1:0] bit_no    = FIRST_BIT;
  logic [LATCH_W-1:0]  tcount    = '0;
  logic                gap_phase = 1'b0;
  logic                frame_on  = 1'b0;
  logic                line_q    = 1'b0;
  cfg_t                shadow    = CFG_RESET;

  level_pair_t line_levels_due [$];
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent   = 0;
  bit          quiet        = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // rise then fall at the current count; fall wins on a tie
  function automatic void fire_edges();
    logic bit_val;
    bit_val = cur_color[bit_no];
    if (tcount == LATCH_W'(shadow.rise)) line_q = 1'b1;
    if (tcount == LATCH_W'(shadow.one_fall) ||
        (!bit_val && tcount == LATCH_W'(shadow.zero_fall))) line_q = 1'b0;
  endfunction

  function automatic void advance_line_model(action_e act, logic [IDX_W-1:0] idx,
                                             logic [COLOR_W-1:0] color);
    logic [LATCH_W-1:0] nxt;
    case (act)
      ACT_TICK: begin
        if (frame_on) begin
          nxt = tcount + 1'b1;
          if (gap_phase) begin
            tcount = nxt;
            line_q = 1'b0;
          end else if (nxt >= LATCH_W'(shadow.period)) begin
            if (bit_no != '0) begin
              bit_no = bit_no - 1'b1;
              tcount = '0;
              fire_edges();
            end else begin
              line_q = 1'b0;
              pix_no = pix_no + 1'b1;
              if (pix_no < shadow.pixels) begin
                bit_no    = FIRST_BIT;
                cur_color = (pix_no < NUM_PIXELS) ? color_mem[pix_no[PIX_AW-1:0]] : '0;
                tcount    = '0;
                fire_edges();
              end else begin
                gap_phase = 1'b1;
                tcount    = nxt;
              end
            end
          end else begin
            tcount = nxt;
            fire_edges();
          end
          if (gap_phase && tcount == shadow.latch_end) begin
            frame_on  = 1'b0;
            gap_phase = 1'b0;
            tcount    = '0;
          end
        end
      end
      ACT_WRITE: begin
        if (idx < NUM_PIXELS) color_mem[idx[PIX_AW-1:0]] = color;
      end
      ACT_REFRESH: begin
        frame_on  = 1'b1;
        gap_phase = 1'b0;
        pix_no    = '0;
        bit_no    = FIRST_BIT;
        tcount    = '0;
        cur_color = color_mem[0];
        fire_edges();
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(action_e act, logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] color,
                           bit typed, bit t_line, bit t_busy);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.action      <= act;
    item_if.pixel_index <= idx;
    item_if.color       <= color;
    do @(posedge clk_i); while (!item_if.ready);
    items_sent++;
    advance_line_model(act, idx, color);
    line_levels_due.push_back(typed ? level_pair_t'{t_line, t_busy}
                                    : level_pair_t'{line_q, frame_on});
  endtask

  task automatic send(action_e act, logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] color);
    send_item(act, idx, color, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    item_if.valid <= 1'b0;
    while (line_levels_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_RISE:      shadow.rise      = data[CNT_W-1:0];
      REG_ZERO_FALL: shadow.zero_fall = data[CNT_W-1:0];
      REG_ONE_FALL:  shadow.one_fall  = data[CNT_W-1:0];
      REG_PERIOD:    shadow.period    = data[CNT_W-1:0];
      REG_LATCH_END: shadow.latch_end = data[LATCH_W-1:0];
      REG_PIXELS:    shadow.pixels    = data[PIXCNT_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits above the register width are sometimes filled with junk
  function automatic logic [CFG_DATA_W-1:0] with_junk(int val, int width);
    logic [CFG_DATA_W-1:0] keep;
    keep = CFG_DATA_W'((32'd1 << width) - 1);
    if ($urandom_range(0, 1) == 1)
      return (CFG_DATA_W'($urandom()) & ~keep) | (CFG_DATA_W'(val) & keep);
    return CFG_DATA_W'(val) & keep;
  endfunction

  task automatic set_config(int rise, int zf, int of, int per, int latch, int pix);
    cfg_write(REG_RISE,      with_junk(rise,  CNT_W));
    cfg_write(REG_ZERO_FALL, with_junk(zf,    CNT_W));
    cfg_write(REG_ONE_FALL,  with_junk(of,    CNT_W));
    cfg_write(REG_PERIOD,    with_junk(per,   CNT_W));
    cfg_write(REG_LATCH_END, with_junk(latch, LATCH_W));
    cfg_write(REG_PIXELS,    with_junk(pix,   PIXCNT_W));
    if ($urandom_range(0, 2) == 0)
      cfg_write(($urandom_range(0, 1) == 1) ? REG_SPARE : REG_SPARE_HI,
                CFG_DATA_W'($urandom()));
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom());
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom());
    return IDX_W'($urandom_range(0, 5));
  endfunction

  // load some colors, start a frame, then tick it out, with some noise mixed in when noisy
  task automatic run_frame(bit noisy, int tick_cap, int n_writes);
    int steps;
    int r;
    for (int i = 0; i < n_writes; i++) send(ACT_WRITE, pick_index(), pick_color());
    send(ACT_REFRESH, IDX_W'($urandom()), COLOR_W'($urandom()));
    steps = 0;
    while (frame_on && steps < tick_cap) begin
      r = noisy ? $urandom_range(0, 99) : 99;
      if (r < 3)       send(ACT_WRITE, pick_index(), pick_color());
      else if (r == 3) send(ACT_REFRESH, IDX_W'($urandom()), COLOR_W'($urandom()));
      else if (r < 6)  send(ACT_NONE, IDX_W'($urandom()), COLOR_W'($urandom()));
      else             send(ACT_TICK, IDX_W'($urandom()), COLOR_W'($urandom()));
      steps++;
    end
    repeat ($urandom_range(0, 3)) send(ACT_TICK, IDX_W'($urandom()), COLOR_W'($urandom()));
  endtask

  // stimulus
  initial begin
    int per;
    int start_cnt;
    int cap;
    foreach (color_mem[i]) color_mem[i] = '0;
    rst_ni              = 1'b0;
    item_if.valid       <= 1'b0;
    item_if.action      <= ACT_TICK;
    item_if.pixel_index <= '0;
    item_if.color       <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_RISE;
    cfg_if.data         <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].act, DIR_ROWS[i].idx, DIR_ROWS[i].color,
                DIR_ROWS[i].typed, DIR_ROWS[i].line, DIR_ROWS[i].busy);

    cfg_write(REG_SPARE, '1);
    cfg_write(REG_SPARE_HI, '0);
    // tie of rise and zero-fall, pixel count of zero sends one pixel
    set_config(2, 2, 3, 4, 6, 0);
    run_frame(1'b1, 300, 3);
    // rise at count zero, latch gap ends at once
    set_config(0, 1, 1, 2, 2, 1);
    run_frame(1'b0, 300, 4);
    // top of every timing range and a full 64-pixel frame, cut short by the next setting
    set_config(4095, 4095, 4095, 4095, 65535, 64);
    run_frame(1'b1, 100, 2);

    while (items_sent < RANDOM_END) begin
      quiet     = ($urandom_range(0, 3) == 0);
      per       = $urandom_range(0, 6);
      start_cnt = (per == 0) ? 1 : per;
      set_config($urandom_range(0, per + 1), $urandom_range(0, per + 1),
                 $urandom_range(0, per + 1), per, start_cnt + $urandom_range(0, 20),
                 $urandom_range(0, 3));
      cap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 4000;
      if (cap > int'(RANDOM_END - items_sent) + 50)
        cap = int'(RANDOM_END - items_sent) + 50;
      run_frame(1'b1, cap, $urandom_range(0, 4));
    end

    quiet = 1'b1;
    // latch end below the period, then at the counter top: the gap runs on toward the counter wrap
    set_config(0, 1, 2, 3, 2, 1);
    run_frame(1'b0, 100, 1);
    set_config(0, 1, 1, 2, 65535, 1);
    run_frame(1'b0, 80, 1);
    item_if.valid <= 1'b0;

    while (line_levels_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("addressable_led_serial_encoder regression: pass");
    else
      $display("addressable_led_serial_encoder regression: fail");
    $finish;
  end

  // result side: checks each word, stalls in bursts, one long hold-off
  initial begin
    level_pair_t exp_w;
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (line_levels_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: unexpected word line %0b busy %0b", $time,
                     res_if.line_level, res_if.busy_res);
        end else begin
          exp_w = line_levels_due.pop_front();
          if (exp_w.line !== res_if.line_level || exp_w.busy !== res_if.busy_res) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("%0t: word %0d line exp %0b got %0b, busy exp %0b got %0b", $time,
                       results_seen, exp_w.line, res_if.line_level, exp_w.busy,
                       res_if.busy_res);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 60) begin
        // long hold so the command queue fills and input backs up
        hold_done = 1'b1;
        hold_left = 119;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 18);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #4000000;
    $display("addressable_led_serial_encoder regression: fail");
    $finish;
  end

endmodule

// ===== addressable_led_serial_encoder.f =====
+incdir+hdl
hdl/aled_pkg.sv
hdl/aled_if.sv
hdl/aled_front.sv
hdl/aled_fifo.sv
hdl/aled_back.sv
hdl/addressable_led_serial_encoder.sv
hdl/aled_checker.sv
dv/tb_top.sv
